@@ rtl/assert_macros.svh @@
// assertion macros for the rate limiter rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// implication checked at every rising edge, held off while reset is low
`define ASSERT_CLK(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// plain invariant checked at every rising edge outside reset
`define ASSERT_ALWAYS(label, expr, msg) \
    `ASSERT_CLK(label, (expr), msg)

`endif

@@ rtl/rleb_pkg.sv @@
package rleb_pkg;

    // event codes
    typedef enum logic [1:0] {
        OP_CHECK = 2'd0,
        OP_DONE  = 2'd1,
        OP_CLEAR = 2'd2,
        OP_NONE  = 2'd3
    } t_op;

    // configuration register indexes
    typedef enum logic [1:0] {
        CFG_MIN_INTERVAL = 2'd0,
        CFG_BASE_BACKOFF = 2'd1,
        CFG_MAX_BACKOFF  = 2'd2,
        CFG_LIMIT_CODE   = 2'd3
    } t_cfg_idx;

    localparam int unsigned CFG_DATA_W = 20;

    localparam logic [19:0] MIN_INTERVAL_RST = 20'd1000;
    localparam logic [19:0] BASE_BACKOFF_RST = 20'd2000;
    localparam logic [19:0] MAX_BACKOFF_RST  = 20'd120000;
    localparam logic [7:0]  LIMIT_CODE_RST   = 8'd22;

    localparam logic [19:0] MIN_INTERVAL_FLOOR = 20'd10;
    localparam logic [20:0] FAIL_DECAY_MS      = 21'd2000;
    localparam logic [20:0] OK_DECAY_MS        = 21'd1000;
    // largest backoff: full cap plus half of it as jitter
    localparam logic [20:0] BACKOFF_BOUND      = 21'd1572864;

    typedef struct packed {
        logic [1:0]  operation;
        logic [31:0] now_ms;
        logic [7:0]  exit_status;
        logic [15:0] jitter_fraction;
    } t_in_word;

    typedef struct packed {
        logic [20:0] wait_ms;
        logic        throttled;
        logic [7:0]  hit_count;
        logic [20:0] backoff_now_ms;
        logic [31:0] request_total;
        logic [31:0] limit_hit_total;
        logic [31:0] throttle_total;
    } t_out_word;

endpackage

@@ rtl/rate_limiter_exponential_backoff.sv @@
// Exponential backoff rate limiter with jitter. Each input word is an event
// stamped with a millisecond time: a check returns the milliseconds still to
// wait before the next request (the rest of the stored backoff while it runs,
// else the rest of the minimum interval), a completion updates the hit count
// and the backoff from its exit code, a clear zeroes all state. Exactly one
// output word comes back per event, carrying the state after that event. It
// is held in the input register, then the output register; one event is taken
// every cycle unless the output stalls, the single state update (shift, cap,
// one 20x16 multiply for the jitter, add) being the only per-event work. The
// user writes configuration via the plain write port only while the block is idle; the block does not enforce this.
`include "assert_macros.svh"

module rate_limiter_exponential_backoff (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // configuration write port
    input  logic                              i_cfg_we,
    input  logic [1:0]                        i_cfg_idx,
    input  logic [rleb_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    // event words in
    input  logic                              i_in_valid,
    output logic                              o_in_ready,
    input  rleb_pkg::t_in_word                i_in_word,
    // result words out
    output logic                              o_out_valid,
    input  logic                              i_out_ready,
    output rleb_pkg::t_out_word               o_out_word
);

    // configuration registers
    logic [19:0] r_min_interval;
    logic [19:0] r_base_backoff;
    logic [19:0] r_max_backoff;
    logic [7:0]  r_limit_code;

    // limiter state
    logic [31:0] r_last_time, n_last_time;
    logic [7:0]  r_hits,      n_hits;
    logic [20:0] r_backoff,   n_backoff;
    logic [31:0] r_req_cnt,   n_req_cnt;
    logic [31:0] r_limit_cnt, n_limit_cnt;
    logic [31:0] r_thr_cnt,   n_thr_cnt;

    // pipeline registers
    logic                 r_in_valid;
    rleb_pkg::t_in_word   r_in;
    logic                 r_out_valid;
    rleb_pkg::t_out_word  r_out, n_out;

    logic w_adv;

    // check path
    logic [31:0] w_elapsed;
    logic [19:0] w_interval;
    logic [20:0] w_wait;

    // rate-limit path
    logic [7:0]  w_hits_up;
    logic [7:0]  w_shift;
    logic [39:0] w_shifted;
    logic [19:0] w_part;
    logic [35:0] w_prod;
    logic [20:0] w_new_backoff;
    logic [20:0] w_decay_floor;

    function automatic logic [31:0] sat_inc32(input logic [31:0] v);
        sat_inc32 = (v == 32'hFFFF_FFFF) ? v : v + 32'd1;
    endfunction

    // the event moves on when the output register is free or being emptied
    assign w_adv       = r_in_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready  = !r_in_valid || w_adv;
    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out;

    // wait computation for a check
    assign w_elapsed  = r_in.now_ms - r_last_time;
    assign w_interval = (r_min_interval < rleb_pkg::MIN_INTERVAL_FLOOR)
                        ? rleb_pkg::MIN_INTERVAL_FLOOR : r_min_interval;

    always_comb begin
        w_wait = '0;
        if (r_backoff != '0 && w_elapsed < {11'd0, r_backoff}) begin
            w_wait = r_backoff - w_elapsed[20:0];
        end else if (w_elapsed < {12'd0, w_interval}) begin
            w_wait = {1'b0, w_interval - w_elapsed[19:0]};
        end
    end

    // new backoff after a rate-limit hit: capped exponential part plus jitter
    assign w_hits_up = (r_hits == 8'd255) ? r_hits : r_hits + 8'd1;
    assign w_shift   = w_hits_up - 8'd1;
    assign w_shifted = {20'd0, r_base_backoff} << w_shift[4:0];

    always_comb begin
        if (w_shift >= 8'd21) begin
            // any nonzero base has long passed the cap by now
            w_part = (r_base_backoff == '0) ? '0 : r_max_backoff;
        end else if (w_shifted > {20'd0, r_max_backoff}) begin
            w_part = r_max_backoff;
        end else begin
            w_part = w_shifted[19:0];
        end
    end

    // jitter is part times the Q0.16 fraction over two
    assign w_prod        = {16'd0, w_part} * {20'd0, r_in.jitter_fraction};
    assign w_new_backoff = {1'b0, w_part} + {2'd0, w_prod[35:17]};

    assign w_decay_floor = (r_in.exit_status != '0) ? rleb_pkg::FAIL_DECAY_MS
                                                     : rleb_pkg::OK_DECAY_MS;

    // state update and result word
    always_comb begin
        n_last_time = r_last_time;
        n_hits      = r_hits;
        n_backoff   = r_backoff;
        n_req_cnt   = r_req_cnt;
        n_limit_cnt = r_limit_cnt;
        n_thr_cnt   = r_thr_cnt;
        n_out       = '0;

        unique case (r_in.operation)
            rleb_pkg::OP_CHECK: begin
                n_out.wait_ms   = w_wait;
                n_out.throttled = (w_wait != '0);
                if (w_wait != '0) begin
                    n_thr_cnt = sat_inc32(r_thr_cnt);
                end
            end
            rleb_pkg::OP_DONE: begin
                n_req_cnt   = sat_inc32(r_req_cnt);
                n_last_time = r_in.now_ms;
                // limit code is tested first, so it wins even when zero
                if (r_in.exit_status == r_limit_code) begin
                    n_limit_cnt = sat_inc32(r_limit_cnt);
                    n_hits      = w_hits_up;
                    n_backoff   = w_new_backoff;
                end else begin
                    n_hits    = (r_hits != '0) ? r_hits - 8'd1 : r_hits;
                    n_backoff = (r_backoff > w_decay_floor) ? (r_backoff >> 1) : '0;
                end
            end
            rleb_pkg::OP_CLEAR: begin
                n_last_time = '0;
                n_hits      = '0;
                n_backoff   = '0;
                n_req_cnt   = '0;
                n_limit_cnt = '0;
                n_thr_cnt   = '0;
            end
            default: begin
                // unused code: state unchanged, reported as is
            end
        endcase

        n_out.hit_count       = n_hits;
        n_out.backoff_now_ms  = n_backoff;
        n_out.request_total   = n_req_cnt;
        n_out.limit_hit_total = n_limit_cnt;
        n_out.throttle_total  = n_thr_cnt;
    end

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min_interval <= rleb_pkg::MIN_INTERVAL_RST;
            r_base_backoff <= rleb_pkg::BASE_BACKOFF_RST;
            r_max_backoff  <= rleb_pkg::MAX_BACKOFF_RST;
            r_limit_code   <= rleb_pkg::LIMIT_CODE_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                rleb_pkg::CFG_MIN_INTERVAL: r_min_interval <= i_cfg_data;
                rleb_pkg::CFG_BASE_BACKOFF: r_base_backoff <= i_cfg_data;
                rleb_pkg::CFG_MAX_BACKOFF:  r_max_backoff  <= i_cfg_data;
                rleb_pkg::CFG_LIMIT_CODE:   r_limit_code   <= i_cfg_data[7:0];
                default: begin
                end
            endcase
        end
    end

    // control and state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_last_time <= '0;
            r_hits      <= '0;
            r_backoff   <= '0;
            r_req_cnt   <= '0;
            r_limit_cnt <= '0;
            r_thr_cnt   <= '0;
        end else begin
            if (o_in_ready) begin
                r_in_valid <= i_in_valid;
            end
            if (w_adv) begin
                r_out_valid <= 1'b1;
                r_last_time <= n_last_time;
                r_hits      <= n_hits;
                r_backoff   <= n_backoff;
                r_req_cnt   <= n_req_cnt;
                r_limit_cnt <= n_limit_cnt;
                r_thr_cnt   <= n_thr_cnt;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_in <= i_in_word;
        end
        if (w_adv) begin
            r_out <= n_out;
        end
    end

    // a word waiting in the input register is never dropped
    `ASSERT_CLK(a_in_held, (r_in_valid && !w_adv) |=> r_in_valid,
                "input word lost while output stalled")
    // clear leaves all state at zero
    `ASSERT_CLK(a_clear_zero,
                (w_adv && r_in.operation == rleb_pkg::OP_CLEAR) |=>
                (r_hits == '0 && r_backoff == '0 && r_req_cnt == '0 &&
                 r_limit_cnt == '0 && r_thr_cnt == '0 && r_last_time == '0),
                "clear left state behind")
    // throttled flag agrees with the wait value
    `ASSERT_CLK(a_thr_wait,
                r_out_valid |-> (r_out.throttled == (r_out.wait_ms != '0)),
                "throttled flag disagrees with wait")
    // backoff never passes cap plus half jitter
    `ASSERT_ALWAYS(a_backoff_bound, r_backoff < rleb_pkg::BACKOFF_BOUND,
                   "backoff out of range")

endmodule
